// ----- hw/rtl/pts_pkg.sv -----
package pts_pkg;

  localparam int AccFracBits = 40;
  localparam int SatBits = 26;
  localparam int TimeW = 24;
  localparam int OutW = 23;
  localparam int Degree = 12;
  localparam logic [23:0] PeriodReset = 24'd1250000;

  // Coefficients in millionths, indexed by degree.
  localparam longint CoefMicro [0:12] = '{
    -64'sd271777, -64'sd6385159, 64'sd147615860, -64'sd10647949391,
    64'sd131706621239, -64'sd772109569471, 64'sd2677405855402,
    -64'sd5893232388210, 64'sd8393025147604, -64'sd7675036282053,
    64'sd4339908790252, -64'sd1379605690202, 64'sd188447160408
  };

  function automatic logic coef_neg(input int deg);
    return CoefMicro[deg] < 0;
  endfunction

  // Magnitude with frac fractional bits, rounded to nearest, ties away.
  function automatic logic [127:0] coef_mag(input int deg, input int frac);
    logic [127:0] m;
    m = (CoefMicro[deg] < 0) ? 128'(-CoefMicro[deg]) : 128'(CoefMicro[deg]);
    m = ((m << frac) + 128'd500000) / 128'd1000000;
    return m;
  endfunction

  typedef struct packed {
    logic neg;
    logic decided;
    logic dec_neg;
  } pts_flags_t;

endpackage

// ----- hw/rtl/pts_norm.sv -----
// Normalized time u = 5t / (4T) with F fractional bits, one quotient bit per stage.
module pts_norm #(
  parameter int ACC_FRAC_BITS = pts_pkg::AccFracBits
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [23:0] time_us,
  input  logic [23:0] period,
  output logic out_valid,
  output logic big,
  output logic [ACC_FRAC_BITS+7:0] u
);
  localparam int QW = ACC_FRAC_BITS + 8;
  localparam int DW = 27;

  logic [QW:0] vld;
  logic [QW:0] bg;
  logic [DW-1:0] den [QW+1];
  logic [DW:0] rem [QW+1];
  logic [7:0] num [QW+1];
  logic [QW-1:0] quo [QW+1];

  logic [23:0] per1;
  logic [26:0] t5;
  assign per1 = (period == '0) ? 24'd1 : period;
  assign t5 = {3'd0, time_us} + {1'b0, time_us, 2'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  // The dividend is t5 followed by F zeros. When 5t < 1024T the quotient bits
  // above the low QW are zero, so the partial remainder after the top 19
  // dividend bits is just those bits; stage 0 starts from there and the
  // stages then bring in the low 8 bits of t5 and the F zeros, MSB first.
  always_ff @(posedge clk) begin
    if (en) begin
      den[0] <= {1'b0, per1, 2'b0};
      rem[0] <= {9'd0, t5[26:8]};
      num[0] <= t5[7:0];
      quo[0] <= '0;
      bg[0] <= ({10'd0, t5} >= {3'd0, per1, 10'd0});
      for (int s = 0; s < QW; s++) begin
        logic [DW:0] r;
        r = {rem[s][DW-1:0], num[s][7]};
        if (r >= {1'b0, den[s]}) begin
          rem[s+1] <= r - {1'b0, den[s]};
          quo[s+1] <= {quo[s][QW-2:0], 1'b1};
        end else begin
          rem[s+1] <= r;
          quo[s+1] <= {quo[s][QW-2:0], 1'b0};
        end
        den[s+1] <= den[s];
        num[s+1] <= {num[s][6:0], 1'b0};
        bg[s+1] <= bg[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign big = bg[QW];
  assign u = quo[QW];
endmodule

// ----- hw/rtl/pts_horner.sv -----
// One Horner step per three stages: partial products, product sum and shift,
// then the sign-magnitude add of the next coefficient.
module pts_horner #(
  parameter int ACC_FRAC_BITS = pts_pkg::AccFracBits
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic big,
  input  logic [ACC_FRAC_BITS+7:0] u,
  output logic out_valid,
  output pts_pkg::pts_flags_t flags,
  output logic [ACC_FRAC_BITS+26:0] mag
);
  localparam int F = ACC_FRAC_BITS;
  localparam int UW = F + 8;
  localparam int MW = F + 27;
  localparam int NS = pts_pkg::Degree;
  localparam int AC = (MW + 2) / 3;
  localparam int UC = (UW + 1) / 2;
  localparam int PPW = AC + UC;
  localparam int SW = 3 * AC + 2 * UC;
  localparam int PW = MW + UW - F + 1;
  localparam logic [PW-1:0] SatLim = PW'(1) << (pts_pkg::SatBits + F);

  function automatic logic [MW-1:0] coef_at(input int deg);
    return MW'(pts_pkg::coef_mag(deg, F));
  endfunction

  localparam logic [MW-1:0] TopMag = coef_at(pts_pkg::Degree);
  localparam logic TopNeg = pts_pkg::coef_neg(pts_pkg::Degree);

  logic [3*NS-1:0] vld;
  logic [MW-1:0] cmag_tab [NS];
  logic [NS-1:0] cneg_tab;

  logic [MW-1:0] acc_in [NS];
  pts_pkg::pts_flags_t fl_in [NS];
  logic [UW-1:0] u_in [NS];

  logic [PPW-1:0] pp_a [NS][6];
  pts_pkg::pts_flags_t fl_a [NS];
  logic [UW-1:0] u_a [NS];

  logic [PW-1:0] p_b [NS];
  pts_pkg::pts_flags_t fl_b [NS];
  logic [UW-1:0] u_b [NS];

  logic [MW-1:0] acc_c [NS];
  pts_pkg::pts_flags_t fl_c [NS];
  logic [UW-1:0] u_c [NS];

  for (genvar g = 0; g < NS; g++) begin : g_coef
    localparam logic [MW-1:0] CMag = coef_at(pts_pkg::Degree - 1 - g);
    localparam logic CNeg = pts_pkg::coef_neg(pts_pkg::Degree - 1 - g);
    assign cmag_tab[g] = CMag;
    assign cneg_tab[g] = CNeg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3*NS-2:0], in_valid};
    end
  end

  always_comb begin
    acc_in[0] = TopMag;
    fl_in[0].neg = TopNeg;
    fl_in[0].decided = big;
    fl_in[0].dec_neg = 1'b0;
    u_in[0] = u;
    for (int k = 1; k < NS; k++) begin
      acc_in[k] = acc_c[k-1];
      fl_in[k] = fl_c[k-1];
      u_in[k] = u_c[k-1];
    end
  end

  // Once a word is decided its accumulator is never looked at again.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        logic [3*AC-1:0] ax;
        logic [2*UC-1:0] ux;
        logic [SW-1:0] row [3];
        logic [SW-1:0] sum;
        logic [PW-1:0] cm;
        logic [PW-1:0] s;
        logic sn;
        pts_pkg::pts_flags_t nf;
        ax = (3*AC)'(acc_in[k]);
        ux = (2*UC)'(u_in[k]);
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 2; j++) begin
            pp_a[k][2*i+j] <= {{UC{1'b0}}, ax[AC*i +: AC]} * {{AC{1'b0}}, ux[UC*j +: UC]};
          end
        end
        fl_a[k] <= fl_in[k];
        u_a[k] <= u_in[k];

        for (int i = 0; i < 3; i++) begin
          row[i] = SW'(pp_a[k][2*i]) + (SW'(pp_a[k][2*i+1]) << UC);
        end
        sum = row[0] + (row[1] << AC) + (row[2] << (2*AC));
        p_b[k] <= PW'(sum >> F);
        fl_b[k] <= fl_a[k];
        u_b[k] <= u_a[k];

        cm = PW'(cmag_tab[k]);
        if (fl_b[k].neg == cneg_tab[k]) begin
          s = p_b[k] + cm;
          sn = fl_b[k].neg;
        end else if (p_b[k] >= cm) begin
          s = p_b[k] - cm;
          sn = fl_b[k].neg;
        end else begin
          s = cm - p_b[k];
          sn = cneg_tab[k];
        end
        nf.neg = sn;
        nf.decided = (s >= SatLim);
        nf.dec_neg = sn;
        acc_c[k] <= s[MW-1:0];
        fl_c[k] <= fl_b[k].decided ? fl_b[k] : nf;
        u_c[k] <= u_b[k];
      end
    end
  end

  assign out_valid = vld[3*NS-1];
  assign flags = fl_c[NS-1];
  assign mag = acc_c[NS-1];
endmodule

// ----- hw/rtl/pts_clamp.sv -----
// Clamp, round to Q.16 and negate.
module pts_clamp #(
  parameter int ACC_FRAC_BITS = pts_pkg::AccFracBits
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  pts_pkg::pts_flags_t flags,
  input  logic [ACC_FRAC_BITS+26:0] mag,
  output logic out_valid,
  output logic [22:0] setpoint_mm_q16,
  output logic was_clamped
);
  localparam int F = ACC_FRAC_BITS;
  localparam int MW = F + 27;
  localparam logic [MW-1:0] Ten = MW'(10) << F;
  localparam logic [MW-1:0] Tfive = MW'(35) << F;
  localparam logic [MW-1:0] Half = MW'(1) << (F - 17);

  logic hi, lo;
  logic [MW-1:0] m, r;
  always_comb begin
    hi = flags.decided ? !flags.dec_neg : (!flags.neg && mag > Ten);
    lo = flags.decided ? flags.dec_neg : (flags.neg && mag > Tfive);
    m = hi ? Ten : (lo ? Tfive : mag);
    r = (m + Half) >> (F - 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      setpoint_mm_q16 <= (hi || !(lo || flags.neg)) ? 23'(-r) : r[22:0];
      was_clamped <= hi || lo;
    end
  end
endmodule

// ----- hw/rtl/polynomial_trajectory_setpoint.sv -----
// Pipeline: ACC_FRAC_BITS + 9 divider stages, 36 Horner stages, one output stage.
// Throughput: one word per cycle; the whole pipeline advances when the output is free.
// A stall freezes every stage; a skid-free design where ready follows the output register.
// Reset clears all valid bits and loads the cycle period with 1250000 us.
module polynomial_trajectory_setpoint #(
  parameter int ACC_FRAC_BITS = pts_pkg::AccFracBits
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // time_us [23:0]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,   // setpoint_mm_q16 [22:0], zero [23]
  output logic m_tuser           // was_clamped
);
  logic [23:0] period;
  logic en;
  logic n_valid, n_big, h_valid;
  logic [ACC_FRAC_BITS+7:0] u;
  pts_pkg::pts_flags_t flags;
  logic [ACC_FRAC_BITS+26:0] mag;
  logic [22:0] sp;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= pts_pkg::PeriodReset;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  // The pipeline moves whenever the output register is empty or being read.
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  pts_norm #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_norm (
    .clk, .rst, .en, .in_valid(s_tvalid), .time_us(s_tdata), .period,
    .out_valid(n_valid), .big(n_big), .u
  );

  pts_horner #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_horner (
    .clk, .rst, .en, .in_valid(n_valid), .big(n_big), .u,
    .out_valid(h_valid), .flags, .mag
  );

  pts_clamp #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_clamp (
    .clk, .rst, .en, .in_valid(h_valid), .flags, .mag,
    .out_valid(m_tvalid), .setpoint_mm_q16(sp), .was_clamped(m_tuser)
  );

  assign m_tdata = {1'b0, sp};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output");
endmodule
